FILE: rtl/tsld_pkg.sv
// ----------------------------------------------------------------------------
// tsld_pkg
// Shared widths, reset constants and beat/result types for the deframer.
// ----------------------------------------------------------------------------
package tsld_pkg;

    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 14;   // max_payload register
    localparam int DLEN_W   = 14;   // delivered_len field
    localparam int LENFLD_W = 16;   // length field on the wire

    localparam logic [CFG_W-1:0] MAX_PAYLOAD_RST = 14'd8192;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_OVERSIZE = 1'b1;

    // one registered input beat
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } beat_t;

    typedef struct packed {
        logic              status;
        logic              data_valid;
        logic [BYTE_W-1:0] data_byte;
        logic              frame_end;
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] frame_slot;
        logic [DLEN_W-1:0] delivered_len;
    } result_t;

endpackage

FILE: rtl/tsld_ifs.sv
// ----------------------------------------------------------------------------
// tsld channel interfaces
// Valid/ready channels for the received byte stream and the parsed results.
// ----------------------------------------------------------------------------
interface tsld_byte_if;
    logic                       valid;
    logic                       ready;
    logic [tsld_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tsld_result_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic                        data_valid;
    logic [tsld_pkg::BYTE_W-1:0] data_byte;
    logic                        frame_end;
    logic [tsld_pkg::BYTE_W-1:0] frame_type;
    logic [tsld_pkg::BYTE_W-1:0] frame_slot;
    logic [tsld_pkg::DLEN_W-1:0] delivered_len;

    modport source (output valid, output status, output data_valid, output data_byte,
                    output frame_end, output frame_type, output frame_slot,
                    output delivered_len, input ready);
    modport sink   (input valid, input status, input data_valid, input data_byte,
                    input frame_end, input frame_type, input frame_slot,
                    input delivered_len, output ready);
endinterface

FILE: rtl/tsld_in_stage.sv
// ----------------------------------------------------------------------------
// tsld_in_stage
// Input register: captures one byte beat and holds it until the parser
// consumes it.
// ----------------------------------------------------------------------------
module tsld_in_stage
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [tsld_pkg::BYTE_W-1:0] in_data,
    output logic                        in_ready,
    input  logic                        consume,
    output tsld_pkg::beat_t             beat
);

    logic                        valid_reg;
    logic [tsld_pkg::BYTE_W-1:0] data_reg;

    // a slot frees up in the same cycle the parser takes the held beat
    assign in_ready = !valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;

endmodule

FILE: rtl/tsld_parser.sv
// ----------------------------------------------------------------------------
// tsld_parser
// Header/payload state machine with the result register behind it.
// ----------------------------------------------------------------------------
module tsld_parser
#(
    parameter int MAX_FRAME_PAYLOAD = 8192
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  tsld_pkg::beat_t            beat,
    input  logic [tsld_pkg::CFG_W-1:0] max_payload,
    output logic                       consume,
    output logic                       res_valid,
    output tsld_pkg::result_t          res,
    input  logic                       res_ready
);

    localparam int LEN_W = $clog2(MAX_FRAME_PAYLOAD + 1);
    localparam int CMP_W = (LEN_W > tsld_pkg::CFG_W) ? LEN_W : tsld_pkg::CFG_W;
    localparam logic [tsld_pkg::LENFLD_W-1:0] LEN_LIMIT =
        tsld_pkg::LENFLD_W'(MAX_FRAME_PAYLOAD);

    typedef enum logic [2:0] {
        PH_TYPE  = 3'd0,
        PH_SLOT  = 3'd1,
        PH_LENHI = 3'd2,
        PH_LENLO = 3'd3,
        PH_BODY  = 3'd4
    } phase_t;

    phase_t                      phase_reg,  phase_next;
    logic [tsld_pkg::BYTE_W-1:0] type_reg,   type_next;
    logic [tsld_pkg::BYTE_W-1:0] slot_reg,   slot_next;
    logic [tsld_pkg::BYTE_W-1:0] lenhi_reg,  lenhi_next;
    logic [LEN_W-1:0]            length_reg, length_next;
    logic [LEN_W-1:0]            count_reg,  count_next;
    logic                        res_valid_reg;
    tsld_pkg::result_t           res_reg,    res_next;

    logic                          has_res;
    logic                          out_free;
    logic [tsld_pkg::LENFLD_W-1:0] len_word;
    logic [CMP_W-1:0]              count_cmp;
    logic [CMP_W-1:0]              length_cmp;
    logic [CMP_W-1:0]              max_cmp;
    logic [CMP_W-1:0]              dlen_cmp;
    logic                          deliver;

    assign len_word   = {lenhi_reg, beat.data};
    assign count_cmp  = CMP_W'(count_reg);
    assign length_cmp = CMP_W'(length_reg);
    assign max_cmp    = CMP_W'(max_payload);
    assign deliver    = count_cmp < max_cmp;
    assign dlen_cmp   = (length_cmp < max_cmp) ? length_cmp : max_cmp;

    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        slot_next   = slot_reg;
        lenhi_next  = lenhi_reg;
        length_next = length_reg;
        count_next  = count_reg;
        has_res     = 1'b0;

        res_next               = '0;
        res_next.status        = tsld_pkg::STATUS_OK;
        res_next.frame_type    = type_reg;
        res_next.frame_slot    = slot_reg;

        unique case (phase_reg)
            PH_SLOT:
            begin
                slot_next  = beat.data;
                phase_next = PH_LENHI;
            end
            PH_LENHI:
            begin
                lenhi_next = beat.data;
                phase_next = PH_LENLO;
            end
            PH_LENLO:
            begin
                if (len_word > LEN_LIMIT)
                begin
                    phase_next      = PH_TYPE;
                    has_res         = 1'b1;
                    res_next.status = tsld_pkg::STATUS_OVERSIZE;
                end
                else if (len_word == '0)
                begin
                    phase_next         = PH_TYPE;
                    has_res            = 1'b1;
                    res_next.frame_end = 1'b1;
                end
                else
                begin
                    length_next = len_word[LEN_W-1:0];
                    count_next  = '0;
                    phase_next  = PH_BODY;
                end
            end
            PH_BODY:
            begin
                // count stays below length here, so the increment cannot wrap
                count_next = count_reg + LEN_W'(1);
                if (count_next >= length_reg)
                begin
                    phase_next             = PH_TYPE;
                    has_res                = 1'b1;
                    res_next.frame_end     = 1'b1;
                    res_next.delivered_len = tsld_pkg::DLEN_W'(dlen_cmp);
                    res_next.data_valid    = deliver;
                    res_next.data_byte     = deliver ? beat.data : '0;
                end
                else if (deliver)
                begin
                    has_res             = 1'b1;
                    res_next.data_valid = 1'b1;
                    res_next.data_byte  = beat.data;
                end
            end
            default:
            begin
                type_next  = beat.data;
                phase_next = PH_SLOT;
            end
        endcase
    end

    // a beat with no result never waits on the output side
    assign out_free = !res_valid_reg || res_ready;
    assign consume  = beat.valid && (!has_res || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TYPE;
            type_reg      <= '0;
            slot_reg      <= '0;
            lenhi_reg     <= '0;
            length_reg    <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (consume)
            begin
                phase_reg  <= phase_next;
                type_reg   <= type_next;
                slot_reg   <= slot_next;
                lenhi_reg  <= lenhi_next;
                length_reg <= length_next;
                count_reg  <= count_next;
            end
            if (consume && has_res)
            begin
                res_valid_reg <= 1'b1;
                res_reg       <= res_next;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // ------------------------------------------------------------------------
    a_err_is_bare: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.status |->
            !res_reg.frame_end && !res_reg.data_valid && res_reg.delivered_len == '0)
        else $error("error result carries data or frame end");

    a_err_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        consume && has_res && res_next.status |=> phase_reg == PH_TYPE)
        else $error("parser did not return to type byte after error");

    a_len_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.frame_end |-> res_reg.delivered_len == '0)
        else $error("delivered length outside frame end");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> count_reg < length_reg && length_reg != '0)
        else $error("payload count ran past frame length");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_ready |=> res_valid_reg)
        else $error("pending result dropped while stalled");

endmodule

FILE: rtl/type_slot_length_deframer.sv
// ----------------------------------------------------------------------------
// type_slot_length_deframer
// Splits a byte stream into type/slot/length/payload frames and emits one
// result beat per delivered payload byte, frame end or length error.
// ----------------------------------------------------------------------------
//  channel  dir  handshake         payload
//  rx       in   valid/ready       rx_byte[7:0]
//  res      out  valid/ready       status, data_valid, data_byte, frame_end,
//                                  frame_type, frame_slot, delivered_len
//  cfg      in   cfg_we (no ready) cfg_wdata[13:0] -> max_payload
//
//  one byte per cycle sustained while results are taken; a byte crosses an
//  input register and then the result register before its result is valid
//  type, slot, len-high and dropped non-final payload bytes yield no result beat
//  a stalled result only holds up bytes that produce a result
//  rst_n clears the parser to type-byte phase and max_payload to 8192
// ----------------------------------------------------------------------------
module type_slot_length_deframer
#(
    parameter int MAX_FRAME_PAYLOAD = 8192
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    tsld_byte_if.sink                  rx,
    tsld_result_if.source              res,
    input  logic                       cfg_we,
    input  logic [tsld_pkg::CFG_W-1:0] cfg_wdata
);

    logic [tsld_pkg::CFG_W-1:0] max_payload_reg;
    tsld_pkg::beat_t            beat;
    logic                       consume;
    logic                       res_valid;
    tsld_pkg::result_t          res_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= tsld_pkg::MAX_PAYLOAD_RST;
        end
        else if (cfg_we)
        begin
            max_payload_reg <= cfg_wdata;
        end
    end

    tsld_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_data  (rx.rx_byte),
        .in_ready (rx.ready),
        .consume  (consume),
        .beat     (beat)
    );

    tsld_parser #(
        .MAX_FRAME_PAYLOAD (MAX_FRAME_PAYLOAD)
    ) u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat        (beat),
        .max_payload (max_payload_reg),
        .consume     (consume),
        .res_valid   (res_valid),
        .res         (res_data),
        .res_ready   (res.ready)
    );

    assign res.valid         = res_valid;
    assign res.status        = res_data.status;
    assign res.data_valid    = res_data.data_valid;
    assign res.data_byte     = res_data.data_byte;
    assign res.frame_end     = res_data.frame_end;
    assign res.frame_type    = res_data.frame_type;
    assign res.frame_slot    = res_data.frame_slot;
    assign res.delivered_len = res_data.delivered_len;

endmodule

FILE: test/tsld_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tsld_frame_checker
// Watches the byte and result channels of the deframer, tracks the header
// and payload parse of every accepted byte beat, and compares each result
// beat field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module tsld_frame_checker
#(
    parameter int FRAME_LIMIT = 8192
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    tsld_byte_if                       rx,
    tsld_result_if                     res,
    input  logic                       cfg_we,
    input  logic [tsld_pkg::CFG_W-1:0] cfg_wdata,
    output int                         results_due,
    output int                         fail_count
);

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_SLOT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY
    } parse_phase_t;

    parse_phase_t                phase;
    logic [tsld_pkg::BYTE_W-1:0] type_q;
    logic [tsld_pkg::BYTE_W-1:0] slot_q;
    logic [tsld_pkg::BYTE_W-1:0] len_hi_q;
    logic [tsld_pkg::DLEN_W-1:0] body_len;
    logic [tsld_pkg::DLEN_W-1:0] body_count;
    logic [tsld_pkg::CFG_W-1:0]  max_payload;

    tsld_pkg::result_t predicted_results[$];

    // advances the parse by one byte; returns 1 when the byte yields a result
    function automatic bit parse_byte(input logic [tsld_pkg::BYTE_W-1:0] b,
                                      output tsld_pkg::result_t r);
        logic [tsld_pkg::LENFLD_W-1:0] len_field;
        bit                            deliver;
        r = '0;
        r.status = tsld_pkg::STATUS_OK;
        r.frame_type = type_q;
        r.frame_slot = slot_q;
        parse_byte = 1'b0;
        case (phase)
            PH_SLOT:
            begin
                slot_q = b;
                phase = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                len_hi_q = b;
                phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_field = {len_hi_q, b};
                r.frame_slot = slot_q;
                if (len_field > FRAME_LIMIT)
                begin
                    r.status = tsld_pkg::STATUS_OVERSIZE;
                    phase = PH_TYPE;
                    parse_byte = 1'b1;
                end
                else if (len_field == 0)
                begin
                    r.frame_end = 1'b1;
                    phase = PH_TYPE;
                    parse_byte = 1'b1;
                end
                else
                begin
                    body_len = len_field[tsld_pkg::DLEN_W-1:0];
                    body_count = '0;
                    phase = PH_BODY;
                end
            end
            PH_BODY:
            begin
                deliver = body_count < max_payload;
                body_count = body_count + 1'b1;
                r.data_valid = deliver;
                r.data_byte = deliver ? b : '0;
                if (body_count >= body_len)
                begin
                    r.frame_end = 1'b1;
                    r.delivered_len = (body_len < max_payload) ? body_len : max_payload;
                    phase = PH_TYPE;
                    parse_byte = 1'b1;
                end
                else
                begin
                    parse_byte = deliver;
                end
            end
            default:
            begin
                type_q = b;
                phase = PH_SLOT;
            end
        endcase
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tsld_pkg::result_t fresh;
        tsld_pkg::result_t oldest;
        if (!rst_n)
        begin
            phase = PH_TYPE;
            type_q = '0;
            slot_q = '0;
            len_hi_q = '0;
            body_len = '0;
            body_count = '0;
            max_payload = tsld_pkg::MAX_PAYLOAD_RST;
            predicted_results.delete();
            fail_count = 0;
            results_due <= 0;
        end
        else
        begin
            if (cfg_we)
                max_payload = cfg_wdata;
            if (rx.valid && rx.ready)
            begin
                if (parse_byte(rx.rx_byte, fresh))
                    predicted_results.push_back(fresh);
            end
            if (res.valid && res.ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: result beat expected none actual %0h/%0h/%0h/%0h/%0h/%0h/%0h",
                             $time, res.status, res.data_valid, res.data_byte,
                             res.frame_end, res.frame_type, res.frame_slot,
                             res.delivered_len);
                    fail_count++;
                end
                else
                begin
                    oldest = predicted_results.pop_front();
                    check_field("status", 16'(oldest.status), 16'(res.status));
                    check_field("data_valid", 16'(oldest.data_valid), 16'(res.data_valid));
                    check_field("data_byte", 16'(oldest.data_byte), 16'(res.data_byte));
                    check_field("frame_end", 16'(oldest.frame_end), 16'(res.frame_end));
                    check_field("frame_type", 16'(oldest.frame_type), 16'(res.frame_type));
                    check_field("frame_slot", 16'(oldest.frame_slot), 16'(res.frame_slot));
                    check_field("delivered_len", 16'(oldest.delivered_len),
                                16'(res.delivered_len));
                end
            end
            results_due <= predicted_results.size();
        end
    end

endmodule

FILE: test/type_slot_length_deframer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// type_slot_length_deframer_test
// Streams directed and random frames, oversize headers and stray bytes into
// the deframer under several max_payload settings, with bursty input and a
// stalling result side; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module type_slot_length_deframer_test;

    localparam int FRAME_LIMIT = 8192;

    typedef enum int {
        RX_STEADY,
        RX_CHOPPY,
        RX_LIGHT
    } rx_mode_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [tsld_pkg::CFG_W-1:0] cfg_wdata;
    int                         results_due;
    int                         fail_count;
    bit                         holdoff_armed;
    bit                         holdoff_done;

    logic [tsld_pkg::BYTE_W-1:0] stream_bytes[$];

    tsld_byte_if   rx_if ();
    tsld_result_if res_if ();

    type_slot_length_deframer #(
        .MAX_FRAME_PAYLOAD (FRAME_LIMIT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_if),
        .res       (res_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    tsld_frame_checker #(
        .FRAME_LIMIT (FRAME_LIMIT)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx_if),
        .res         (res_if),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .results_due (results_due),
        .fail_count  (fail_count)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic void add_header(input logic [7:0] ftype, input logic [7:0] fslot,
                                       input logic [15:0] len_field);
        stream_bytes.push_back(ftype);
        stream_bytes.push_back(fslot);
        stream_bytes.push_back(len_field[15:8]);
        stream_bytes.push_back(len_field[7:0]);
    endfunction

    function automatic void add_frame(input int len);
        add_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(len));
        repeat (len)
            stream_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // mostly well-formed frames; the rest oversize headers and stray bytes
    function automatic void add_traffic(input int count);
        int stop;
        int pick;
        int len;
        stop = stream_bytes.size() + count;
        while (stream_bytes.size() < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                if (pick < 8)
                    len = 0;
                else if (pick < 16)
                    len = $urandom_range(25, 200);
                else
                    len = $urandom_range(1, 24);
                add_frame(len);
            end
            else if (pick < 90)
            begin
                case (pick % 3)
                    0:       len = FRAME_LIMIT + 1;
                    1:       len = 16'hFFFF;
                    default: len = $urandom_range(FRAME_LIMIT + 1, 16'hFFFF);
                endcase
                add_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(len));
            end
            else
            begin
                // stray bytes above 0x20 can only ever form oversize lengths,
                // whole groups of four keep the parse aligned on frames
                repeat (4 * $urandom_range(1, 2))
                    stream_bytes.push_back(8'($urandom_range(8'h21, 8'hFF)));
            end
        end
    endfunction

    task automatic send_byte(input logic [tsld_pkg::BYTE_W-1:0] b);
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
    endtask

    task automatic pump_stream();
        int burst;
        int gap;
        while (stream_bytes.size() > 0)
        begin
            burst = $urandom_range(1, 32);
            while (burst > 0 && stream_bytes.size() > 0)
            begin
                send_byte(stream_bytes.pop_front());
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                rx_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        rx_if.valid <= 1'b0;
    endtask

    // wait until every predicted result has come out and the pipe is empty
    task automatic settle();
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_max_payload(input logic [tsld_pkg::CFG_W-1:0] value);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // result side: segments of steady, choppy and light stalling, plus one
    // long hold-off while the sender keeps pushing beats
    initial
    begin
        int       span;
        rx_mode_t mode;
        res_if.ready <= 1'b0;
        forever
        begin
            span = $urandom_range(4, 80);
            mode = rx_mode_t'($urandom_range(RX_STEADY, RX_LIGHT));
            if (holdoff_armed && !holdoff_done)
            begin
                @(posedge clk);
                res_if.ready <= 1'b0;
                repeat (400) @(posedge clk);
                holdoff_done = 1'b1;
            end
            else
            begin
                repeat (span)
                begin
                    @(posedge clk);
                    case (mode)
                        RX_STEADY: res_if.ready <= 1'b1;
                        RX_CHOPPY: res_if.ready <= 1'($urandom_range(0, 1));
                        default:   res_if.ready <= ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        rx_if.valid <= 1'b0;
        rx_if.rx_byte <= '0;
        holdoff_armed = 1'b0;
        holdoff_done = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero length, single byte, short frame, length just over the limit,
        // all-ones length; the first oversize header is followed straight by the second
        add_header(8'h00, 8'hFF, 16'd0);
        add_header(8'hFF, 8'h00, 16'd1);
        stream_bytes.push_back(8'hFF);
        add_header(8'hA5, 8'h5A, 16'd2);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'h55);
        add_header(8'h3C, 8'hC3, 16'(FRAME_LIMIT + 1));
        add_header(8'h81, 8'h7E, 16'hFFFF);
        pump_stream();
        settle();

        holdoff_armed = 1'b1;
        add_traffic(180);
        pump_stream();

        write_max_payload('0);
        add_traffic(90);
        pump_stream();

        write_max_payload(tsld_pkg::CFG_W'(FRAME_LIMIT));
        add_traffic(90);
        pump_stream();

        write_max_payload(tsld_pkg::CFG_W'(1));
        add_traffic(90);
        pump_stream();

        write_max_payload(tsld_pkg::CFG_W'($urandom_range(2, 30)));
        add_traffic(90);
        pump_stream();

        // one long frame, mostly dropped
        write_max_payload(tsld_pkg::CFG_W'(13));
        add_frame(120);
        add_traffic(30);
        pump_stream();

        write_max_payload(tsld_pkg::CFG_W'($urandom_range(0, FRAME_LIMIT)));
        add_traffic(90);
        pump_stream();

        settle();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
